FILE: sv/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/pse_pkg.sv
package pse_pkg;

    localparam int DATA_W = 32;
    localparam int CH_W   = 8;
    localparam int OPND_W = 9;

    localparam logic [CH_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [CH_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [CH_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [CH_W-1:0] CH_DIV  = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO = 8'd48;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIVZERO   = 2'd3
    } t_err;

    typedef struct packed {
        logic                     is_op;
        t_op                      op;
        logic signed [OPND_W-1:0] operand;
        logic                     last;
    } t_cmd;

endpackage

FILE: sv/pse_ram.sv
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pse_front.sv
module pse_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [pse_pkg::CH_W-1:0]   i_ch,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_ready,
    output pse_pkg::t_cmd              o_cmd
);
    import pse_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.is_op   = 1'b1;
        n_cmd.op      = OP_ADD;
        n_cmd.operand = $signed({1'b0, i_ch} - {1'b0, CH_ZERO});
        n_cmd.last    = i_last;
        unique case (i_ch)
            CH_ADD:  n_cmd.op = OP_ADD;
            CH_SUB:  n_cmd.op = OP_SUB;
            CH_MUL:  n_cmd.op = OP_MUL;
            CH_DIV:  n_cmd.op = OP_DIV;
            default: n_cmd.is_op = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: sv/pse_fifo.sv
module pse_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pse_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output pse_pkg::t_cmd o_cmd
);
    import pse_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/pse_div.sv
module pse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pse_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pse_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pse_pkg::DATA_W-1:0]  o_quotient
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } t_dstate;

    t_dstate           r_state, n_state;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic              r_neg, n_neg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_q_out, n_q_out;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign rem_sh     = {r_rem, r_quo[DATA_W-1]};
    assign diff       = rem_sh - {1'b0, r_dvs};
    assign ge         = !diff[DATA_W];
    assign o_done     = r_done;
    assign o_quotient = r_q_out;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_q_out = r_q_out;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_rem   = '0;
                    n_quo   = i_dividend[DATA_W-1] ? ('0 - i_dividend) : i_dividend;
                    n_dvs   = i_divisor[DATA_W-1] ? ('0 - i_divisor) : i_divisor;
                    n_neg   = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
                    n_cnt   = '0;
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                n_rem = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = D_FIX;
                end
            end
            D_FIX: begin
                n_q_out = r_neg ? ('0 - r_quo) : r_quo;
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_q_out <= n_q_out;
    end

endmodule

FILE: sv/pse_back.sv
`include "assert_macros.svh"

module pse_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  pse_pkg::t_cmd               i_cmd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pse_pkg::DATA_W-1:0]  o_value,
    output logic [1:0]                  o_err
);
    import pse_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_END  = 4'b1000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_tos, n_tos;
    t_err              r_err, n_err;
    t_op               r_op, n_op;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    t_err              r_out_err, n_out_err;

    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W-1:0] cmd_ext;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    t_bstate           fin_state;

    assign cnt_m1    = r_count - CNT_W'(1);
    assign cnt_m2    = r_count - CNT_W'(2);
    assign mul_lo    = ram_rdata * r_tos;
    assign cmd_ext   = DATA_W'(i_cmd.operand);
    assign out_free  = !r_out_valid || i_ready;
    assign fin_state = r_last ? S_END : S_IDLE;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_err   = r_out_err;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_m1[ADDR_W-1:0]),
        .i_wdata (r_tos),
        .i_raddr (cnt_m2[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ram_rdata),
        .i_divisor  (r_tos),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_tos       = r_tos;
        n_err       = r_err;
        n_op        = r_op;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_cmd.op;
                    n_last  = i_cmd.last;
                    n_state = i_cmd.last ? S_END : S_IDLE;
                    if (r_err == ERR_OK) begin
                        if (!i_cmd.is_op) begin
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_err = ERR_OVERFLOW;
                            end else begin
                                ram_we  = (r_count != '0);
                                n_tos   = cmd_ext;
                                n_count = r_count + CNT_W'(1);
                            end
                        end else if (r_count < CNT_W'(2)) begin
                            n_err = ERR_UNDERFLOW;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                end
            end
            S_EXEC: begin
                n_count = cnt_m1;
                n_state = fin_state;
                unique case (r_op)
                    OP_ADD: n_tos = ram_rdata + r_tos;
                    OP_SUB: n_tos = ram_rdata - r_tos;
                    OP_MUL: n_tos = mul_lo;
                    OP_DIV: begin
                        if (r_tos == '0) begin
                            n_err   = ERR_DIVZERO;
                            n_count = cnt_m2;
                        end else begin
                            div_start = 1'b1;
                            n_count   = r_count;
                            n_state   = S_DIV;
                        end
                    end
                    default: n_state = fin_state;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_tos   = div_quo;
                    n_count = cnt_m1;
                    n_state = fin_state;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    if (r_err != ERR_OK) begin
                        n_out_err = r_err;
                    end else if (r_count == '0) begin
                        n_out_err = ERR_UNDERFLOW;
                    end else begin
                        n_out_err   = ERR_OK;
                        n_out_value = r_tos;
                    end
                    n_count = '0;
                    n_err   = ERR_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ERR_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos       <= n_tos;
        r_op        <= n_op;
        r_last      <= n_last;
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(STACK_DEPTH), "stack count above depth")
    `ASSERT_NEXT(a_div_wait, i_clk, i_rst_n, div_start, r_state == S_DIV, "divide start without wait")
    `ASSERT_NEXT(a_end_clear, i_clk, i_rst_n, r_state == S_END && out_free, r_count == '0 && r_err == ERR_OK && r_out_valid, "end of expression left state behind")
    `ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err != ERR_OK && r_state != S_END, r_err == $past(r_err), "error code changed mid expression")

endmodule

FILE: sv/postfix_stack_evaluator.sv
// Channel   Dir  Fields (lowest bit up)         Handshake
// s_axis    in   tdata: ch[7:0]; tlast: last     tvalid/tready
// m_axis    out  tdata: value[31:0]; tuser: error[1:0]   tvalid/tready
//
// Operand: pushed in the back end's idle state; + - *: stack read, then execute.
// Divide: the back end waits in its divide state on the iterative divider, which gives 1 bit/cycle.
// Last item: the back end then loads the result register in its end state.
// Reset (synchronous, low) empties the stack and clears the error; stack RAM is not cleared.
// The front register and 2-entry queue keep taking items while the back end works;
// the back end waits on the divider and, at expression end, on a full result register.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[31:0]
    output logic [1:0]  m_axis_tuser    // error[1:0]
);
    import pse_pkg::*;

    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_f_cmd;
    logic w_q_valid;
    logic w_q_ready;
    t_cmd w_q_cmd;

    pse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ch    (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cmd   (w_f_cmd)
    );

    pse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cmd   (w_f_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd)
    );

    pse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_cmd   (w_q_cmd),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (m_axis_tdata),
        .o_err   (m_axis_tuser)
    );

endmodule
